@@ hdl/ecr_pkg.sv @@
// ----------------------------------------------------------------------------
// ecr_pkg: shared types and constants for the 2D elastic collision response
// Body flag bit positions, register reset value and pipeline payload structs.
// ----------------------------------------------------------------------------
package ecr_pkg;

	// body_flags bit positions
	localparam int unsigned FLAG_A_STATIC = 0;
	localparam int unsigned FLAG_B_STATIC = 1;
	localparam int unsigned FLAG_A_PHYS   = 2;
	localparam int unsigned FLAG_B_PHYS   = 3;

	// repel gain after reset, 0.75 in Q8.8
	localparam logic [15:0] REPEL_GAIN_RST = 16'd192;

	// per-request context carried down the whole pipe
	typedef struct packed {
		logic signed [31:0] vax;
		logic signed [31:0] vay;
		logic signed [31:0] vbx;
		logic signed [31:0] vby;
		logic [38:0]        rep;
		logic               sa;
		logic               sb;
		logic               pass;
		logic               mzero;
		logic               degen;
		logic               neg_x;
		logic               neg_y;
	} ctx_t;

	// masses until the weight division
	typedef struct packed {
		logic [31:0] ma;
		logic [31:0] mb;
		logic [32:0] msum;
	} mass_t;

	// square root lane: remainder, root, normalized distance
	typedef struct packed {
		logic [63:0] x;
		logic [63:0] r;
		logic [30:0] nax;
		logic [30:0] nay;
	} root_t;

	// division lanes: normal components and mass weights
	typedef struct packed {
		logic [32:0] rx;
		logic [32:0] ry;
		logic [31:0] len;
		logic [30:0] qx;
		logic [30:0] qy;
		logic [33:0] ra;
		logic [33:0] rb;
		logic [32:0] msum;
		logic [30:0] qa;
		logic [30:0] qb;
	} div_t;

	// one result
	typedef struct packed {
		logic signed [31:0] vax;
		logic signed [31:0] vay;
		logic signed [31:0] vbx;
		logic signed [31:0] vby;
		logic               status;
	} res_t;

endpackage

@@ hdl/elastic_collision_response_2d.sv @@
// ----------------------------------------------------------------------------
// elastic_collision_response_2d: new velocities of two colliding bodies
// Throughput: one request per cycle while the skid register is empty;
// depth set by the 32-step square root and the 31-step normal/weight
// dividers, one step per stage.
// A skid register behind the output keeps input acceptance off out_ready.
// Reset clears all valid bits and sets repel_gain to 0.75 (Q8.8 192).
// ----------------------------------------------------------------------------
module elastic_collision_response_2d (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [15:0]        cfg_wr_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] pos_a_x,
	input  logic signed [31:0] pos_a_y,
	input  logic signed [31:0] pos_b_x,
	input  logic signed [31:0] pos_b_y,
	input  logic signed [31:0] vel_a_x,
	input  logic signed [31:0] vel_a_y,
	input  logic signed [31:0] vel_b_x,
	input  logic signed [31:0] vel_b_y,
	input  logic [31:0]        mass_a,
	input  logic [31:0]        mass_b,
	input  logic [30:0]        overlap_depth,
	input  logic [3:0]         body_flags,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] new_vel_a_x,
	output logic signed [31:0] new_vel_a_y,
	output logic signed [31:0] new_vel_b_x,
	output logic signed [31:0] new_vel_b_y,
	output logic               status
);

	// floor(a*b) split into 21-bit signed high and 20-bit low parts
	function automatic logic signed [52:0] mul_hi(logic signed [40:0] a,
			logic signed [31:0] b);
		return $signed(a[40:20]) * b;
	endfunction

	function automatic logic signed [52:0] mul_lo(logic signed [40:0] a,
			logic signed [31:0] b);
		return $signed({1'b0, a[19:0]}) * b;
	endfunction

	function automatic logic signed [31:0] sat32(logic signed [43:0] v);
		if (v > 44'sd2147483647) begin
			return 32'sh7fffffff;
		end else if (v < -44'sd2147483648) begin
			return 32'sh80000000;
		end else begin
			return v[31:0];
		end
	endfunction

	logic        en;
	logic [15:0] gain_q;

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= ecr_pkg::REPEL_GAIN_RST;
		end else if (cfg_wr_en) begin
			gain_q <= cfg_wr_data;
		end
	end

	// ---------------- s1: differences, magnitudes, mass sum, repel term ----
	logic               v_s1;
	ecr_pkg::ctx_t      ctx_s1;
	ecr_pkg::mass_t     mass_s1;
	logic [31:0]        ax_s1, ay_s1;

	logic signed [32:0] dx_c, dy_c;
	logic [46:0]        rep_prod_c;
	logic [32:0]        msum_c;
	ecr_pkg::ctx_t      ctx_c;

	always_comb begin
		dx_c       = {pos_b_x[31], pos_b_x} - {pos_a_x[31], pos_a_x};
		dy_c       = {pos_b_y[31], pos_b_y} - {pos_a_y[31], pos_a_y};
		rep_prod_c = {16'b0, overlap_depth} * {31'b0, gain_q};
		msum_c     = {1'b0, mass_a} + {1'b0, mass_b};
		ctx_c.vax   = vel_a_x;
		ctx_c.vay   = vel_a_y;
		ctx_c.vbx   = vel_b_x;
		ctx_c.vby   = vel_b_y;
		ctx_c.rep   = rep_prod_c[46:8];
		ctx_c.sa    = body_flags[ecr_pkg::FLAG_A_STATIC];
		ctx_c.sb    = body_flags[ecr_pkg::FLAG_B_STATIC];
		ctx_c.pass  = !(body_flags[ecr_pkg::FLAG_A_PHYS] && body_flags[ecr_pkg::FLAG_B_PHYS])
			|| (body_flags[ecr_pkg::FLAG_A_STATIC] && body_flags[ecr_pkg::FLAG_B_STATIC]);
		ctx_c.mzero = (msum_c == 33'd0);
		// coinciding positions give no normal
		ctx_c.degen = (dx_c == 33'sd0) && (dy_c == 33'sd0);
		ctx_c.neg_x = dx_c[32];
		ctx_c.neg_y = dy_c[32];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s1       <= ctx_c;
			mass_s1.ma   <= mass_a;
			mass_s1.mb   <= mass_b;
			mass_s1.msum <= msum_c;
			ax_s1        <= dx_c[32] ? 32'(-dx_c) : dx_c[31:0];
			ay_s1        <= dy_c[32] ? 32'(-dy_c) : dy_c[31:0];
		end
	end

	// ---------------- s2: leading one of the larger magnitude ---------------
	logic           v_s2;
	ecr_pkg::ctx_t  ctx_s2;
	ecr_pkg::mass_t mass_s2;
	logic [31:0]    ax_s2, ay_s2;
	logic [4:0]     k_s2;
	logic [31:0]    m_c;
	logic [4:0]     k_c;

	always_comb begin
		m_c = (ax_s1 > ay_s1) ? ax_s1 : ay_s1;
		k_c = 5'd0;
		for (int i = 0; i < 32; i++) begin
			if (m_c[i]) begin
				k_c = 5'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s2       <= ctx_s1;
			mass_s2      <= mass_s1;
			ax_s2        <= ax_s1;
			ay_s2        <= ay_s1;
			k_s2         <= k_c;
		end
	end

	// ---------------- s3: normalize so the larger lies in [2^30, 2^31) -----
	logic           v_s3;
	ecr_pkg::ctx_t  ctx_s3;
	ecr_pkg::mass_t mass_s3;
	logic [30:0]    nax_s3, nay_s3;
	logic [61:0]    wx_c, wy_c;

	always_comb begin
		wx_c = {ax_s2, 30'b0} >> k_s2;
		wy_c = {ay_s2, 30'b0} >> k_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s3  <= ctx_s2;
			mass_s3 <= mass_s2;
			nax_s3  <= wx_c[30:0];
			nay_s3  <= wy_c[30:0];
		end
	end

	// ---------------- s4: squares ------------------------------------------
	logic           v_s4;
	ecr_pkg::ctx_t  ctx_s4;
	ecr_pkg::mass_t mass_s4;
	logic [30:0]    nax_s4, nay_s4;
	logic [61:0]    sqx_s4, sqy_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s4  <= ctx_s3;
			mass_s4 <= mass_s3;
			nax_s4  <= nax_s3;
			nay_s4  <= nay_s3;
			sqx_s4  <= {31'b0, nax_s3} * {31'b0, nax_s3};
			sqy_s4  <= {31'b0, nay_s3} * {31'b0, nay_s3};
		end
	end

	// ---------------- s5: square root, entry 0 loads, 32 digit steps -------
	logic           v_s5    [33];
	ecr_pkg::ctx_t  ctx_s5  [33];
	ecr_pkg::mass_t mass_s5 [33];
	ecr_pkg::root_t root_s5 [33];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5[0] <= 1'b0;
		end else if (en) begin
			v_s5[0] <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s5[0]      <= ctx_s4;
			mass_s5[0]     <= mass_s4;
			root_s5[0].x   <= 64'(sqx_s4) + 64'(sqy_s4);
			root_s5[0].r   <= 64'd0;
			root_s5[0].nax <= nax_s4;
			root_s5[0].nay <= nay_s4;
		end
	end

	for (genvar i = 0; i < 32; i++) begin : g_root
		localparam logic [63:0] ROOT_BIT = 64'd1 << (62 - 2 * i);
		ecr_pkg::root_t rt_c;
		logic [63:0]    trial_c;

		// one result bit per stage
		always_comb begin
			rt_c    = root_s5[i];
			trial_c = root_s5[i].r + ROOT_BIT;
			if (root_s5[i].x >= trial_c) begin
				rt_c.x = root_s5[i].x - trial_c;
				rt_c.r = (root_s5[i].r >> 1) + ROOT_BIT;
			end else begin
				rt_c.r = root_s5[i].r >> 1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s5[i+1] <= 1'b0;
			end else if (en) begin
				v_s5[i+1] <= v_s5[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ctx_s5[i+1]  <= ctx_s5[i];
				mass_s5[i+1] <= mass_s5[i];
				root_s5[i+1] <= rt_c;
			end
		end
	end

	// ---------------- s6: restoring division, one quotient bit per stage ---
	logic          v_s6   [31];
	ecr_pkg::ctx_t ctx_s6 [31];
	ecr_pkg::div_t div_s6 [31];
	ecr_pkg::div_t div_init_c;

	always_comb begin
		div_init_c.rx   = {2'b0, root_s5[32].nax};
		div_init_c.ry   = {2'b0, root_s5[32].nay};
		div_init_c.len  = root_s5[32].r[31:0];
		div_init_c.qx   = 31'd0;
		div_init_c.qy   = 31'd0;
		div_init_c.ra   = {2'b0, mass_s5[32].ma};
		div_init_c.rb   = {2'b0, mass_s5[32].mb};
		div_init_c.msum = mass_s5[32].msum;
		div_init_c.qa   = 31'd0;
		div_init_c.qb   = 31'd0;
	end

	for (genvar j = 0; j < 31; j++) begin : g_div
		ecr_pkg::div_t d_in;
		ecr_pkg::ctx_t c_in;
		logic          v_in;
		ecr_pkg::div_t d_c;
		logic [32:0]   rem_x, rem_y;
		logic [33:0]   rem_a, rem_b;
		logic          bx, by, ba, bb;

		if (j == 0) begin : g_first
			assign d_in = div_init_c;
			assign c_in = ctx_s5[32];
			assign v_in = v_s5[32];
		end else begin : g_next
			assign d_in = div_s6[j-1];
			assign c_in = ctx_s6[j-1];
			assign v_in = v_s6[j-1];
		end

		// four compare-subtract lanes
		always_comb begin
			bx    = (d_in.rx >= {1'b0, d_in.len});
			by    = (d_in.ry >= {1'b0, d_in.len});
			ba    = (d_in.ra >= {1'b0, d_in.msum});
			bb    = (d_in.rb >= {1'b0, d_in.msum});
			rem_x = bx ? (d_in.rx - {1'b0, d_in.len}) : d_in.rx;
			rem_y = by ? (d_in.ry - {1'b0, d_in.len}) : d_in.ry;
			rem_a = ba ? (d_in.ra - {1'b0, d_in.msum}) : d_in.ra;
			rem_b = bb ? (d_in.rb - {1'b0, d_in.msum}) : d_in.rb;
			d_c    = d_in;
			d_c.rx = {rem_x[31:0], 1'b0};
			d_c.ry = {rem_y[31:0], 1'b0};
			d_c.ra = {rem_a[32:0], 1'b0};
			d_c.rb = {rem_b[32:0], 1'b0};
			d_c.qx = {d_in.qx[29:0], bx};
			d_c.qy = {d_in.qy[29:0], by};
			d_c.qa = {d_in.qa[29:0], ba};
			d_c.qb = {d_in.qb[29:0], bb};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s6[j] <= 1'b0;
			end else if (en) begin
				v_s6[j] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ctx_s6[j] <= c_in;
				div_s6[j] <= d_c;
			end
		end
	end

	// ---------------- s7: signed normal, weights ---------------------------
	logic               v_s7;
	ecr_pkg::ctx_t      ctx_s7;
	logic signed [31:0] nx_s7, ny_s7;
	logic [30:0]        wa_s7, wb_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s7 <= v_s6[30];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s7 <= ctx_s6[30];
			nx_s7  <= ctx_s6[30].neg_x ? -$signed({1'b0, div_s6[30].qx})
				: $signed({1'b0, div_s6[30].qx});
			ny_s7  <= ctx_s6[30].neg_y ? -$signed({1'b0, div_s6[30].qy})
				: $signed({1'b0, div_s6[30].qy});
			wa_s7  <= div_s6[30].qa;
			wb_s7  <= div_s6[30].qb;
		end
	end

	// ---------------- s8: velocity projection products ---------------------
	logic               v_s8;
	ecr_pkg::ctx_t      ctx_s8;
	logic signed [31:0] nx_s8, ny_s8;
	logic [30:0]        wa_s8, wb_s8;
	logic signed [63:0] pv_s8 [8];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s8   <= ctx_s7;
			nx_s8    <= nx_s7;
			ny_s8    <= ny_s7;
			wa_s8    <= wa_s7;
			wb_s8    <= wb_s7;
			pv_s8[0] <= ctx_s7.vax * nx_s7;
			pv_s8[1] <= ctx_s7.vay * ny_s7;
			pv_s8[2] <= ctx_s7.vax * ny_s7;
			pv_s8[3] <= ctx_s7.vay * nx_s7;
			pv_s8[4] <= ctx_s7.vbx * nx_s7;
			pv_s8[5] <= ctx_s7.vby * ny_s7;
			pv_s8[6] <= ctx_s7.vbx * ny_s7;
			pv_s8[7] <= ctx_s7.vby * nx_s7;
		end
	end

	// ---------------- s9: normal and tangent speeds -------------------------
	logic               v_s9;
	ecr_pkg::ctx_t      ctx_s9;
	logic signed [31:0] nx_s9, ny_s9;
	logic [30:0]        wa_s9, wb_s9;
	logic signed [33:0] sa_s9, ua_s9, sb_s9, ub_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9 <= 1'b0;
		end else if (en) begin
			v_s9 <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s9 <= ctx_s8;
			nx_s9  <= nx_s8;
			ny_s9  <= ny_s8;
			wa_s9  <= wa_s8;
			wb_s9  <= wb_s8;
			sa_s9  <= 34'(pv_s8[0] >>> 30) + 34'(pv_s8[1] >>> 30);
			ua_s9  <= 34'(pv_s8[2] >>> 30) - 34'(pv_s8[3] >>> 30);
			sb_s9  <= 34'(pv_s8[4] >>> 30) + 34'(pv_s8[5] >>> 30);
			ub_s9  <= 34'(pv_s8[6] >>> 30) - 34'(pv_s8[7] >>> 30);
		end
	end

	// ---------------- s10: normal speed difference --------------------------
	logic               v_s10;
	ecr_pkg::ctx_t      ctx_s10;
	logic signed [31:0] nx_s10, ny_s10;
	logic [30:0]        wa_s10, wb_s10;
	logic signed [33:0] sa_s10, ua_s10, sb_s10, ub_s10;
	logic signed [34:0] d_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s10 <= 1'b0;
		end else if (en) begin
			v_s10 <= v_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s10 <= ctx_s9;
			nx_s10  <= nx_s9;
			ny_s10  <= ny_s9;
			wa_s10  <= wa_s9;
			wb_s10  <= wb_s9;
			sa_s10  <= sa_s9;
			ua_s10  <= ua_s9;
			sb_s10  <= sb_s9;
			ub_s10  <= ub_s9;
			d_s10   <= 35'(sb_s9) - 35'(sa_s9);
		end
	end

	// ---------------- s11: mass-weighted exchange products ------------------
	logic               v_s11;
	ecr_pkg::ctx_t      ctx_s11;
	logic signed [31:0] nx_s11, ny_s11;
	logic signed [33:0] sa_s11, ua_s11, sb_s11, ub_s11;
	logic signed [66:0] wpa_s11, wpb_s11;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s11 <= 1'b0;
		end else if (en) begin
			v_s11 <= v_s10;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s11 <= ctx_s10;
			nx_s11  <= nx_s10;
			ny_s11  <= ny_s10;
			sa_s11  <= sa_s10;
			ua_s11  <= ua_s10;
			sb_s11  <= sb_s10;
			ub_s11  <= ub_s10;
			wpb_s11 <= d_s10 * $signed({1'b0, wb_s10});
			wpa_s11 <= (-d_s10) * $signed({1'b0, wa_s10});
		end
	end

	// ---------------- s12: new normal speeds --------------------------------
	logic               v_s12;
	ecr_pkg::ctx_t      ctx_s12;
	logic signed [31:0] nx_s12, ny_s12;
	logic signed [40:0] na_s12, nb_s12, ua_s12, ub_s12;
	logic signed [40:0] n1_c, n2_c;
	logic               dyn_c;

	always_comb begin
		dyn_c = !ctx_s11.sa && !ctx_s11.sb;
		n1_c  = 41'(sa_s11) + 41'(wpb_s11 >>> 29) - $signed({2'b0, ctx_s11.rep});
		n2_c  = 41'(sb_s11) + 41'(wpa_s11 >>> 29) + $signed({2'b0, ctx_s11.rep});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s12 <= 1'b0;
		end else if (en) begin
			v_s12 <= v_s11;
		end
	end

	// a static partner mirrors the moving body's normal speed
	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s12 <= ctx_s11;
			nx_s12  <= nx_s11;
			ny_s12  <= ny_s11;
			na_s12  <= dyn_c ? n1_c : -41'(sa_s11);
			nb_s12  <= dyn_c ? n2_c : -41'(sb_s11);
			ua_s12  <= 41'(ua_s11);
			ub_s12  <= 41'(ub_s11);
		end
	end

	// ---------------- s13: back-projection partial products -----------------
	logic               v_s13;
	ecr_pkg::ctx_t      ctx_s13;
	logic signed [52:0] ph_s13 [8];
	logic signed [52:0] pl_s13 [8];
	logic signed [40:0] opa_c  [8];
	logic signed [31:0] opb_c  [8];

	// order: A x n, A x t, A y n, A y t, then B
	always_comb begin
		opa_c[0] = na_s12; opb_c[0] = nx_s12;
		opa_c[1] = ua_s12; opb_c[1] = ny_s12;
		opa_c[2] = na_s12; opb_c[2] = ny_s12;
		opa_c[3] = ua_s12; opb_c[3] = nx_s12;
		opa_c[4] = nb_s12; opb_c[4] = nx_s12;
		opa_c[5] = ub_s12; opb_c[5] = ny_s12;
		opa_c[6] = nb_s12; opb_c[6] = ny_s12;
		opa_c[7] = ub_s12; opb_c[7] = nx_s12;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s13 <= 1'b0;
		end else if (en) begin
			v_s13 <= v_s12;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s13 <= ctx_s12;
			for (int k = 0; k < 8; k++) begin
				ph_s13[k] <= mul_hi(opa_c[k], opb_c[k]);
				pl_s13[k] <= mul_lo(opa_c[k], opb_c[k]);
			end
		end
	end

	// ---------------- s14: full products, floored to Q16.16 ----------------
	logic               v_s14;
	ecr_pkg::ctx_t      ctx_s14;
	logic signed [42:0] q_s14 [8];
	logic signed [72:0] full_c [8];

	always_comb begin
		for (int k = 0; k < 8; k++) begin
			full_c[k] = (73'(ph_s13[k]) <<< 20) + 73'(pl_s13[k]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s14 <= 1'b0;
		end else if (en) begin
			v_s14 <= v_s13;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s14 <= ctx_s13;
			for (int k = 0; k < 8; k++) begin
				q_s14[k] <= 43'(full_c[k] >>> 30);
			end
		end
	end

	// ---------------- s15: combine, saturate, select pass-through ----------
	logic               v_s15;
	ecr_pkg::res_t      res_s15;
	logic signed [43:0] rax_c, ray_c, rbx_c, rby_c;
	logic               ok_c, a_upd_c, b_upd_c, bad_c, dyn14_c;

	always_comb begin
		rax_c   = 44'(q_s14[0]) + 44'(q_s14[1]);
		ray_c   = 44'(q_s14[2]) - 44'(q_s14[3]);
		rbx_c   = 44'(q_s14[4]) + 44'(q_s14[5]);
		rby_c   = 44'(q_s14[6]) - 44'(q_s14[7]);
		dyn14_c = !ctx_s14.sa && !ctx_s14.sb;
		bad_c   = ctx_s14.degen || (dyn14_c && ctx_s14.mzero);
		ok_c    = !ctx_s14.pass && !bad_c;
		a_upd_c = ok_c && !ctx_s14.sa;
		b_upd_c = ok_c && !ctx_s14.sb;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s15 <= 1'b0;
		end else if (en) begin
			v_s15 <= v_s14;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s15.vax    <= a_upd_c ? sat32(rax_c) : ctx_s14.vax;
			res_s15.vay    <= a_upd_c ? sat32(ray_c) : ctx_s14.vay;
			res_s15.vbx    <= b_upd_c ? sat32(rbx_c) : ctx_s14.vbx;
			res_s15.vby    <= b_upd_c ? sat32(rby_c) : ctx_s14.vby;
			res_s15.status <= !ctx_s14.pass && bad_c;
		end
	end

	// ---------------- output register with skid -----------------------------
	logic          out_valid_q, skid_valid_q, take;
	ecr_pkg::res_t out_q, skid_q;

	assign en       = !skid_valid_q;
	assign in_ready = en;
	assign take     = v_s15 && en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			out_valid_q  <= skid_valid_q || take;
			skid_valid_q <= 1'b0;
		end else if (take) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || out_ready) begin
			out_q <= skid_valid_q ? skid_q : res_s15;
		end else if (take) begin
			skid_q <= res_s15;
		end
	end

	assign out_valid   = out_valid_q;
	assign new_vel_a_x = out_q.vax;
	assign new_vel_a_y = out_q.vay;
	assign new_vel_b_x = out_q.vbx;
	assign new_vel_b_y = out_q.vby;
	assign status      = out_q.status;

	// ---------------- checks ------------------------------------------------
	// skid holds data only behind a held output
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid full while output empty");

	// skid fills only when the output was stalled
	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(out_valid_q && !out_ready))
		else $error("skid filled without output stall");

	// a stalled pipe keeps its last request
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!en && v_s15) |=> v_s15)
		else $error("last stage request lost during stall");

endmodule

@@ tb/tb_elastic_collision_response_2d.sv @@
// ----------------------------------------------------------------------------
// tb_elastic_collision_response_2d: self-checking bench for the collision block
// Drives directed and random collision requests through valid/ready with
// random sender gaps and receiver stalls. Results are checked in order
// against a fixed-point predictor, across several repel gain settings.
// ----------------------------------------------------------------------------
module tb_elastic_collision_response_2d;

	typedef struct {
		logic signed [31:0] pax, pay, pbx, pby;
		logic signed [31:0] vax, vay, vbx, vby;
		logic [31:0]        ma, mb;
		logic [30:0]        dep;
		logic [3:0]         flg;
		bit                 typed;
		ecr_pkg::res_t      want;
	} pair_t;

	localparam longint ONE30     = longint'(1) << 30;
	localparam int     CYC_LIMIT = 400000;
	localparam int     LATENCY   = 77;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_wr_en = 1'b0;
	logic [15:0]        cfg_wr_data = '0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic signed [31:0] pos_a_x = '0, pos_a_y = '0, pos_b_x = '0, pos_b_y = '0;
	logic signed [31:0] vel_a_x = '0, vel_a_y = '0, vel_b_x = '0, vel_b_y = '0;
	logic [31:0]        mass_a = '0, mass_b = '0;
	logic [30:0]        overlap_depth = '0;
	logic [3:0]         body_flags = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic signed [31:0] new_vel_a_x, new_vel_a_y, new_vel_b_x, new_vel_b_y;
	logic               status;

	elastic_collision_response_2d u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.pos_a_x(pos_a_x), .pos_a_y(pos_a_y), .pos_b_x(pos_b_x), .pos_b_y(pos_b_y),
		.vel_a_x(vel_a_x), .vel_a_y(vel_a_y), .vel_b_x(vel_b_x), .vel_b_y(vel_b_y),
		.mass_a(mass_a), .mass_b(mass_b), .overlap_depth(overlap_depth),
		.body_flags(body_flags),
		.out_valid(out_valid), .out_ready(out_ready),
		.new_vel_a_x(new_vel_a_x), .new_vel_a_y(new_vel_a_y),
		.new_vel_b_x(new_vel_b_x), .new_vel_b_y(new_vel_b_y),
		.status(status)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	logic [15:0]   gain_q = ecr_pkg::REPEL_GAIN_RST;
	ecr_pkg::res_t vel_pending[$];
	int            errors = 0;
	int            cycles = 0;
	int            send_idle = 0;
	int            recv_stall = 0;

	// floor(a * b / 2^30)
	function automatic longint qmul(longint a, longint b);
		longint hi, lo;
		hi = a >>> 30;
		lo = a - hi * ONE30;
		return hi * b + ((lo * b) >>> 30);
	endfunction

	function automatic longint sat32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic bit [63:0] root64(bit [63:0] x);
		bit [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b = b >> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// new velocities of one colliding pair
	function automatic ecr_pkg::res_t collide(pair_t p, logic [15:0] gain);
		ecr_pkg::res_t o;
		bit            sa, sb, phys;
		longint        dx, dy, nx, ny, s1, u1, s2, u2, wa, wb, rep, n1, n2;
		longint        rax, ray, rbx, rby;
		bit [63:0]     ax, ay, len, msum;
		bit            st;
		sa   = p.flg[ecr_pkg::FLAG_A_STATIC];
		sb   = p.flg[ecr_pkg::FLAG_B_STATIC];
		phys = p.flg[ecr_pkg::FLAG_A_PHYS] && p.flg[ecr_pkg::FLAG_B_PHYS];
		rax = p.vax; ray = p.vay; rbx = p.vbx; rby = p.vby;
		st = 1'b0;
		if (phys && !(sa && sb)) begin
			dx   = longint'(p.pbx) - longint'(p.pax);
			dy   = longint'(p.pby) - longint'(p.pay);
			msum = 64'(p.ma) + 64'(p.mb);
			if ((dx == 0 && dy == 0) || (!sa && !sb && msum == 0)) begin
				st = 1'b1;
			end else begin
				// normalize d into [2^30, 2^31) and form the unit normal
				ax = dx < 0 ? -dx : dx;
				ay = dy < 0 ? -dy : dy;
				while ((ax > ay ? ax : ay) >= (64'd1 << 31)) begin
					ax = ax >> 1; ay = ay >> 1;
				end
				while ((ax > ay ? ax : ay) < (64'd1 << 30)) begin
					ax = ax << 1; ay = ay << 1;
				end
				len = root64(ax * ax + ay * ay);
				nx = longint'((ax << 30) / len);
				ny = longint'((ay << 30) / len);
				if (dx < 0) nx = -nx;
				if (dy < 0) ny = -ny;
				s1 = qmul(p.vax, nx) + qmul(p.vay, ny);
				u1 = qmul(p.vax, ny) - qmul(p.vay, nx);
				s2 = qmul(p.vbx, nx) + qmul(p.vby, ny);
				u2 = qmul(p.vbx, ny) - qmul(p.vby, nx);
				if (!sa && !sb) begin
					wa  = longint'((64'(p.ma) << 30) / msum);
					wb  = longint'((64'(p.mb) << 30) / msum);
					rep = longint'((64'(p.dep) * 64'(gain)) >> 8);
					n1  = s1 + (((s2 - s1) * wb) >>> 29) - rep;
					n2  = s2 + (((s1 - s2) * wa) >>> 29) + rep;
					rax = qmul(n1, nx) + qmul(u1, ny);
					ray = qmul(n1, ny) - qmul(u1, nx);
					rbx = qmul(n2, nx) + qmul(u2, ny);
					rby = qmul(n2, ny) - qmul(u2, nx);
				end else if (sa) begin
					rbx = qmul(-s2, nx) + qmul(u2, ny);
					rby = qmul(-s2, ny) - qmul(u2, nx);
				end else begin
					rax = qmul(-s1, nx) + qmul(u1, ny);
					ray = qmul(-s1, ny) - qmul(u1, nx);
				end
			end
		end
		o.vax = 32'(sat32(rax));
		o.vay = 32'(sat32(ray));
		o.vbx = 32'(sat32(rbx));
		o.vby = 32'(sat32(rby));
		o.status = st;
		return o;
	endfunction

	function automatic pair_t mk(int pax, int pay, int pbx, int pby, int vax, int vay,
			int vbx, int vby, int unsigned ma, int unsigned mb, int unsigned dep,
			logic [3:0] flg);
		pair_t p;
		p.pax = pax; p.pay = pay; p.pbx = pbx; p.pby = pby;
		p.vax = vax; p.vay = vay; p.vbx = vbx; p.vby = vby;
		p.ma = ma; p.mb = mb; p.dep = dep[30:0]; p.flg = flg;
		p.typed = 1'b0;
		p.want = '0;
		return p;
	endfunction

	// same pair, with a result that passes the velocities through
	function automatic pair_t passing(pair_t p, logic st);
		p.typed = 1'b1;
		p.want = '{vax: p.vax, vay: p.vay, vbx: p.vbx, vby: p.vby, status: st};
		return p;
	endfunction

	function automatic logic [31:0] rnd_word();
		case ($urandom_range(9))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2, 3, 4: return 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
			default: return $urandom;
		endcase
	endfunction

	function automatic pair_t rnd_pair();
		pair_t p;
		int    k;
		p = mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 4'b0000);
		p.pax = rnd_word(); p.pay = rnd_word();
		k = $urandom_range(9);
		if (k == 0) begin
			p.pbx = p.pax; p.pby = p.pay;
		end else if (k < 6) begin
			p.pbx = p.pax + 32'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
			p.pby = p.pay + 32'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
		end else begin
			p.pbx = rnd_word(); p.pby = rnd_word();
		end
		p.vax = rnd_word(); p.vay = rnd_word(); p.vbx = rnd_word(); p.vby = rnd_word();
		p.ma = $urandom_range(9) == 0 ? 32'd0 : rnd_word();
		p.mb = $urandom_range(9) == 0 ? 32'd0 : rnd_word();
		p.dep = $urandom_range(3) == 0 ? 31'($urandom) : 31'($urandom_range(0, 32'h0004_0000));
		// mostly physical pairs, mostly both dynamic
		k = $urandom_range(19);
		if (k < 12) p.flg = 4'b1100;
		else if (k < 17) p.flg = {2'b11, 2'($urandom_range(1, 3))};
		else p.flg = 4'($urandom);
		return p;
	endfunction

	// present one request and hold it until accepted
	task automatic send(pair_t p);
		bit took;
		if ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		pos_a_x <= p.pax; pos_a_y <= p.pay; pos_b_x <= p.pbx; pos_b_y <= p.pby;
		vel_a_x <= p.vax; vel_a_y <= p.vay; vel_b_x <= p.vbx; vel_b_y <= p.vby;
		mass_a <= p.ma; mass_b <= p.mb; overlap_depth <= p.dep; body_flags <= p.flg;
		took = 1'b0;
		while (!took) begin
			@(posedge clk);
			took = in_ready;
		end
		vel_pending.push_back(p.typed ? p.want : collide(p, gain_q));
	endtask

	// drain, let the pipe settle, then write the gain register
	task automatic set_gain(logic [15:0] g);
		in_valid <= 1'b0;
		while (vel_pending.size() != 0) @(posedge clk);
		repeat (LATENCY + 20) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= g;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		gain_q = g;
	endtask

	// result checker and receiver stalls
	always @(posedge clk) begin
		ecr_pkg::res_t w;
		if (out_valid && out_ready) begin
			if (vel_pending.size() == 0) begin
				$error("result with no request pending");
				errors++;
			end else begin
				w = vel_pending.pop_front();
				if (new_vel_a_x !== w.vax) begin
					$error("new_vel_a_x exp %0d got %0d", w.vax, new_vel_a_x); errors++;
				end
				if (new_vel_a_y !== w.vay) begin
					$error("new_vel_a_y exp %0d got %0d", w.vay, new_vel_a_y); errors++;
				end
				if (new_vel_b_x !== w.vbx) begin
					$error("new_vel_b_x exp %0d got %0d", w.vbx, new_vel_b_x); errors++;
				end
				if (new_vel_b_y !== w.vby) begin
					$error("new_vel_b_y exp %0d got %0d", w.vby, new_vel_b_y); errors++;
				end
				if (status !== w.status) begin
					$error("status exp %0d got %0d", w.status, status); errors++;
				end
			end
		end
		out_ready <= ($urandom_range(99) >= recv_stall);
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYC_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		pair_t       tab[$];
		logic [15:0] gains[5];
		int          idle_s[5], idle_r[5];
		tab = '{
			passing(mk(1, 2, 3, 4, 32'h7fffffff, 32'h80000000, -5, 5,
				65536, 65536, 100, 4'b0000), 1'b0),
			passing(mk(0, 0, 65536, 0, 65536, 0, -65536, 0,
				65536, 65536, 0, 4'b0111), 1'b0),
			passing(mk(0, 0, 65536, 0, 65536, 0, -65536, 0,
				65536, 65536, 0, 4'b1011), 1'b0),
			passing(mk(0, 0, 65536, 0, 65536, 0, -65536, 0,
				65536, 65536, 0, 4'b1111), 1'b0),
			passing(mk(7, -7, 7, -7, 65536, 3, -65536, 9,
				65536, 65536, 0, 4'b1100), 1'b1),
			passing(mk(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
				1, 2, 3, 4, 0, 0, 0, 4'b1101), 1'b1),
			passing(mk(0, 0, 65536, 0, 65536, 0, -65536, 0,
				0, 0, 65536, 4'b1100), 1'b1),
			mk(0, 0, 65536, 0, 65536, 0, -65536, 0, 65536, 65536, 0, 4'b1100),
			mk(0, 0, 65536, 0, 65536, 0, -65536, 0, 65536, 65536, 65536, 4'b1100),
			mk(0, 0, 0, 65536, 100, 65536, 0, 0, 0, 0, 0, 4'b1101),
			mk(0, 0, 65536, 65536, 65536, 0, 5, -5, 0, 0, 0, 4'b1110),
			mk(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
				32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000,
				32'hffffffff, 32'hffffffff, 32'h7fffffff, 4'b1100),
			mk(32'h7fffffff, 0, 32'h80000000, 1, 32'h80000000, 32'h7fffffff,
				32'h7fffffff, 32'h80000000, 0, 32'hffffffff, 0, 4'b1100),
			mk(0, 0, 3, 4, 32'h7fffffff, 0, 0, 32'h80000000,
				32'hffffffff, 1, 32'h7fffffff, 4'b1100),
			mk(0, 0, -1, 0, 1000, -1000, 2000, 3000, 65536, 131072, 0, 4'b1100),
			mk(100, 200, 100, 201, -1, -1, 1, 1, 1, 0, 12345, 4'b1100),
			mk(0, 0, 65536, -65536, 32'h80000000, 0, 0, 0, 0, 0, 0, 4'b1110),
			mk(0, 0, -65536, -65536, 32'h7fffffff, 32'h7fffffff, 0, 0,
				0, 0, 0, 4'b1110)
		};
		gains  = '{ecr_pkg::REPEL_GAIN_RST, 16'd0, 16'hffff, 16'd256, 16'h0000};
		idle_s = '{0, 54, 0, 35, 20};
		idle_r = '{0, 0, 54, 35, 20};
		gains[4] = 16'($urandom);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int ph = 0; ph < 5; ph++) begin
			if (ph != 0) set_gain(gains[ph]);
			send_idle  = idle_s[ph];
			recv_stall = idle_r[ph];
			if (ph == 0) foreach (tab[i]) send(tab[i]);
			for (int i = 0; i < 140; i++) send(rnd_pair());
		end
		in_valid <= 1'b0;

		while (vel_pending.size() != 0) @(posedge clk);
		repeat (LATENCY + 20) @(posedge clk);
		if (errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
